### src/tsd_pkg.sv
// shared types, constants and the history hash of the tilemap stream decoder
package tsd_pkg;

    localparam int HIST_DEPTH = 64;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // opcode byte fields
    localparam logic [7:0] OP_LITERAL  = 8'hFF;
    localparam logic [1:0] CLS_FETCH   = 2'b00;
    localparam logic [1:0] CLS_DELTA   = 2'b01;
    localparam logic [1:0] CLS_STEP    = 2'b10;
    localparam logic [1:0] CLS_REPEAT  = 2'b11;
    localparam logic [15:0] DELTA_BIAS = 16'd8;

    // work handed from the front part to the back part
    typedef enum logic [2:0] {
        CMD_CLEAR,
        CMD_LITERAL,
        CMD_FETCH,
        CMD_DELTA,
        CMD_INC,
        CMD_DEC,
        CMD_REPEAT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] data;        // literal value, or the opcode byte in the low bits
        logic [5:0]  cnt;         // entries to emit minus one
        logic        stream_end;  // last entry of this command closes the stream
    } cmd_t;

    // history slot: entry[9:0] + 3*flip + 5*palette, modulo the history depth
    function automatic logic [HIST_AW-1:0] hist_slot(input logic [15:0] e);
        logic [HIST_AW-1:0] s;
        s = e[HIST_AW-1:0]
          + HIST_AW'(e[11:10])
          + HIST_AW'({e[11:10], 1'b0})
          + HIST_AW'(e[15:12])
          + HIST_AW'({e[15:12], 2'b00});
        return s;
    endfunction

endpackage

### src/tsd_front.sv
// front part: header parsing, opcode classification and length bookkeeping
module tsd_front (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    output logic         byte_ready,
    input  logic [7:0]   byte_data,
    output logic         push,
    output tsd_pkg::cmd_t cmd,
    input  logic         full
);
    import tsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_HDR2,
        PH_HDR3,
        PH_OP,
        PH_LITLO,
        PH_LITHI
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [22:0] left_reg, left_next;
    logic [15:0] len_lo_reg, len_lo_next;
    logic [7:0]  lit_lo_reg, lit_lo_next;

    logic        accept;
    logic [23:0] length;
    logic [6:0]  want;
    logic [6:0]  take;
    logic [6:0]  take_m1;
    logic [22:0] left_after;

    assign byte_ready = !full;
    assign accept     = byte_valid && !full;
    assign length     = {byte_data, len_lo_reg};

    // entries this opcode asks for, cut at the remaining length
    always_comb
    begin
        case (byte_data[7:6])
            CLS_STEP:   want = {2'b00, byte_data[4:0]} + 7'd1;
            CLS_REPEAT: want = {1'b0, byte_data[5:0]} + 7'd1;
            default:    want = 7'd1;
        endcase
        if (phase_reg == PH_LITHI)
            want = 7'd1;
        take       = (left_reg < {16'b0, want}) ? left_reg[6:0] : want;
        take_m1    = take - 7'd1;
        left_after = left_reg - {16'b0, take};
    end

    // phase sequencing and command build
    always_comb
    begin
        phase_next      = phase_reg;
        left_next       = left_reg;
        len_lo_next     = len_lo_reg;
        lit_lo_next     = lit_lo_reg;
        push            = 1'b0;
        cmd.kind        = CMD_CLEAR;
        cmd.data        = {8'b0, byte_data};
        cmd.cnt         = take_m1[5:0];
        cmd.stream_end  = (left_after == 23'd0);
        if (accept)
        begin
            case (phase_reg)
                PH_HDR0:
                    phase_next = PH_HDR1;
                PH_HDR1:
                begin
                    len_lo_next[7:0] = byte_data;
                    phase_next       = PH_HDR2;
                end
                PH_HDR2:
                begin
                    len_lo_next[15:8] = byte_data;
                    phase_next        = PH_HDR3;
                end
                PH_HDR3:
                begin
                    left_next  = length[23:1];
                    push       = 1'b1;
                    cmd.kind   = CMD_CLEAR;
                    phase_next = (length[23:1] == 23'd0) ? PH_HDR0 : PH_OP;
                end
                PH_OP:
                begin
                    if (byte_data == OP_LITERAL)
                    begin
                        phase_next = PH_LITLO;
                    end
                    else
                    begin
                        push      = 1'b1;
                        left_next = left_after;
                        case (byte_data[7:6])
                            CLS_FETCH: cmd.kind = CMD_FETCH;
                            CLS_DELTA: cmd.kind = CMD_DELTA;
                            CLS_STEP:  cmd.kind = byte_data[5] ? CMD_DEC : CMD_INC;
                            default:   cmd.kind = CMD_REPEAT;
                        endcase
                        phase_next = (left_after == 23'd0) ? PH_HDR0 : PH_OP;
                    end
                end
                PH_LITLO:
                begin
                    lit_lo_next = byte_data;
                    phase_next  = PH_LITHI;
                end
                PH_LITHI:
                begin
                    push       = 1'b1;
                    left_next  = left_after;
                    cmd.kind   = CMD_LITERAL;
                    cmd.data   = {byte_data, lit_lo_reg};
                    phase_next = (left_after == 23'd0) ? PH_HDR0 : PH_OP;
                end
                default:
                    phase_next = PH_HDR1;
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            left_reg   <= '0;
            len_lo_reg <= '0;
            lit_lo_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            len_lo_reg <= len_lo_next;
            lit_lo_reg <= lit_lo_next;
        end
    end

endmodule

### src/tsd_cmd_fifo.sv
// short command queue between the front and back parts
module tsd_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tsd_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output tsd_pkg::cmd_t head_cmd,
    output logic          empty
);
    import tsd_pkg::*;

    cmd_t               store_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full     = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = store_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

### src/tsd_back.sv
// back part: entry generation, history store and output register
module tsd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  tsd_pkg::cmd_t head_cmd,
    input  logic          empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [15:0]   out_entry,
    output logic          out_last,
    output logic          out_end
);
    import tsd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FETCH
    } state_t;

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [5:0]            cnt_reg, cnt_next;
    logic [15:0]           prev_reg, prev_next;
    logic [HIST_DEPTH-1:0] hv_reg, hv_next;
    logic                  rd_hv_reg, rd_hv_next;
    logic                  out_valid_reg, out_valid_next;
    logic [15:0]           out_entry_reg, out_entry_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_end_reg, out_end_next;

    logic [15:0]           hist_mem [HIST_DEPTH];
    logic [15:0]           rd_data_reg;
    logic                  rd_en;
    logic [HIST_AW-1:0]    rd_addr;
    logic                  wr_en;
    logic [HIST_AW-1:0]    wr_addr;
    logic [15:0]           wr_data;

    logic                  slot_free;
    logic [15:0]           gen_entry;
    logic [15:0]           fetch_entry;

    assign out_valid = out_valid_reg;
    assign out_entry = out_entry_reg;
    assign out_last  = out_last_reg;
    assign out_end   = out_end_reg;

    assign slot_free   = !out_valid_reg || out_ready;
    assign rd_addr     = head_cmd.data[HIST_AW-1:0];
    assign fetch_entry = rd_hv_reg ? rd_data_reg : 16'd0;
    assign wr_addr     = hist_slot(gen_entry);
    assign wr_data     = gen_entry;

    // next entry of the running command
    always_comb
    begin
        case (cmd_reg.kind)
            CMD_LITERAL: gen_entry = cmd_reg.data;
            CMD_DELTA:   gen_entry = (prev_reg + {12'b0, cmd_reg.data[3:0]} - DELTA_BIAS)
                                   ^ {4'b0, cmd_reg.data[5:4], 10'b0};
            CMD_INC:     gen_entry = prev_reg + 16'd1;
            CMD_DEC:     gen_entry = prev_reg - 16'd1;
            default:     gen_entry = prev_reg;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cnt_next       = cnt_reg;
        prev_next      = prev_reg;
        hv_next        = hv_reg;
        rd_hv_next     = rd_hv_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_entry_next = out_entry_reg;
        out_last_next  = out_last_reg;
        out_end_next   = out_end_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head_cmd;
                    cnt_next = head_cmd.cnt;
                    case (head_cmd.kind)
                        CMD_CLEAR:
                        begin
                            hv_next   = '0;
                            prev_next = '0;
                        end
                        CMD_FETCH:
                        begin
                            rd_en      = 1'b1;
                            rd_hv_next = hv_reg[rd_addr];
                            state_next = ST_FETCH;
                        end
                        default:
                            state_next = ST_RUN;
                    endcase
                end
            end
            ST_RUN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_entry_next = gen_entry;
                    out_last_next  = (cnt_reg == 6'd0);
                    out_end_next   = (cnt_reg == 6'd0) && cmd_reg.stream_end;
                    prev_next      = gen_entry;
                    if (cmd_reg.kind != CMD_REPEAT)
                    begin
                        wr_en            = 1'b1;
                        hv_next[wr_addr] = 1'b1;
                    end
                    cnt_next = cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                        state_next = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_entry_next = fetch_entry;
                    out_last_next  = 1'b1;
                    out_end_next   = cmd_reg.stream_end;
                    prev_next      = fetch_entry;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= '0;
            cnt_reg       <= '0;
            prev_reg      <= '0;
            hv_reg        <= '0;
            rd_hv_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_entry_reg <= '0;
            out_last_reg  <= 1'b0;
            out_end_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            cnt_reg       <= cnt_next;
            prev_reg      <= prev_next;
            hv_reg        <= hv_next;
            rd_hv_reg     <= rd_hv_next;
            out_valid_reg <= out_valid_next;
            out_entry_reg <= out_entry_next;
            out_last_reg  <= out_last_next;
            out_end_reg   <= out_end_next;
        end
    end

    // history memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            hist_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= hist_mem[rd_addr];
    end

endmodule

### src/tilemap_stream_decoder_unit.sv
// top level of the tilemap stream decoder
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+----------------------------------------------
//  s_axis  | in  | s_tvalid/s_tready | s_tdata: data_byte
//  m_axis  | out | m_tvalid/m_tready | m_tdata: tile_entry, m_tlast: run_end,
//          |     |                   | m_tuser: stream_end
//
// header and literal-low bytes are consumed in the front part. a single-entry
// opcode passes the back part as a queue pop, then an emit; a run is emitted at
// one entry per cycle while the output register is free. a four-deep command queue
// lets input run ahead; s_tready drops while it is full. reset is asynchronous;
// history valid bits clear at once on reset and on the clear command of header
// byte 3, so no clearing pass is needed. m_tready low holds the output register.
module tilemap_stream_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] tile_entry
    output logic        m_tlast,   // run_end
    output logic        m_tuser    // [0] stream_end
);
    import tsd_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // byte parsing
    tsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_tvalid),
        .byte_ready (s_tready),
        .byte_data  (s_tdata),
        .push       (push),
        .cmd        (push_cmd),
        .full       (full)
    );

    // command queue
    tsd_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (empty)
    );

    // entry generation
    tsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_entry (m_tdata),
        .out_last  (m_tlast),
        .out_end   (m_tuser)
    );

endmodule

### tb/tilemap_stream_decoder_unit_test.sv
// self-checking testbench for the tilemap stream decoder top level
`timescale 1ns / 1ps

module tilemap_stream_decoder_unit_test;
    import tsd_pkg::*;

    localparam int RANDOM_ITEMS   = 390;
    localparam int N_DIR          = 26;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 150;
    localparam int DRAIN_CYCLES   = 30;

    typedef enum logic [2:0] {
        WAIT_H0,
        WAIT_H1,
        WAIT_H2,
        WAIT_H3,
        WAIT_OP,
        WAIT_LIT_LO,
        WAIT_LIT_HI
    } phase_t;

    typedef struct packed {
        logic [15:0] entry;
        logic        run_end;
        logic        stream_end;
    } tile_t;

    typedef struct packed {
        logic [7:0] data;
        logic       known;
        tile_t      tile;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    // decoder copy kept by the testbench
    logic [15:0] hist_copy [HIST_DEPTH];
    logic [15:0] prev_tile;
    logic [22:0] tiles_left;
    phase_t      dec_phase;
    logic [7:0]  lit_byte;
    logic [15:0] len_word;

    tile_t new_tiles [$];
    tile_t pending_tiles [$];

    int err_count;
    int sent_count;
    int tile_count;
    int burst_left;

    // directed stream: odd length, every opcode class, run cut off, zero lengths
    row_t dir_rows [N_DIR] = '{
        '{8'h00, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'h21, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'h00, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'h00, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'h00, 1'b1, '{16'h0000, 1'b1, 1'b0}},
        '{8'hFF, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'hFF, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'hFF, 1'b1, '{16'hFFFF, 1'b1, 1'b0}},
        '{8'h13, 1'b1, '{16'hFFFF, 1'b1, 1'b0}},
        '{8'h7F, 1'b1, '{16'h0C06, 1'b1, 1'b0}},
        '{8'h40, 1'b1, '{16'h0BFE, 1'b1, 1'b0}},
        '{8'h80, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'hBF, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'h00, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'h04, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'h00, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'h00, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'hFE, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'h00, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'h00, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'h00, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'h00, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'hFF, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'h01, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'h00, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{8'h00, 1'b0, '{16'h0000, 1'b0, 1'b0}}
    };

    tilemap_stream_decoder_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // history slot from tile index, flip bits and palette
    function automatic int hist_index(input logic [15:0] e);
        return (int'(e[9:0]) + 3 * int'(e[11:10]) + 5 * int'(e[15:12])) % HIST_DEPTH;
    endfunction

    function automatic void remember_tile(input logic [15:0] e);
        hist_copy[hist_index(e)] = e;
    endfunction

    // append one decoded tile unless the stream is used up or new_tiles already holds 64
    function automatic bit push_tile(input logic [15:0] e);
        tile_t t;
        if (tiles_left == 23'd0 || new_tiles.size() >= 64)
            return 1'b0;
        tiles_left   = tiles_left - 23'd1;
        t.entry      = e;
        t.run_end    = 1'b0;
        t.stream_end = (tiles_left == 23'd0);
        new_tiles.push_back(t);
        return 1'b1;
    endfunction

    // advance the decoder copy by one stream byte, tiles land in new_tiles
    function automatic void decode_byte(input logic [7:0] b);
        int cnt;
        logic [15:0] sum;
        new_tiles.delete();
        case (dec_phase)
            WAIT_H1:
            begin
                len_word  = {8'h00, b};
                dec_phase = WAIT_H2;
            end
            WAIT_H2:
            begin
                len_word[15:8] = b;
                dec_phase      = WAIT_H3;
            end
            WAIT_H3:
            begin
                tiles_left = 23'({b, len_word} >> 1);
                foreach (hist_copy[i])
                    hist_copy[i] = 16'h0000;
                prev_tile = 16'h0000;
                dec_phase = (tiles_left == 23'd0) ? WAIT_H0 : WAIT_OP;
            end
            WAIT_LIT_LO:
            begin
                lit_byte  = b;
                dec_phase = WAIT_LIT_HI;
            end
            WAIT_LIT_HI, WAIT_OP:
            begin
                if (dec_phase == WAIT_LIT_HI)
                begin
                    prev_tile = {b, lit_byte};
                    remember_tile(prev_tile);
                    void'(push_tile(prev_tile));
                    dec_phase = WAIT_OP;
                end
                else if (b == OP_LITERAL)
                begin
                    dec_phase = WAIT_LIT_LO;
                    return;
                end
                else
                begin
                    case (b[7:6])
                        CLS_FETCH:
                        begin
                            prev_tile = hist_copy[b[5:0]];
                            void'(push_tile(prev_tile));
                        end
                        CLS_DELTA:
                        begin
                            sum       = prev_tile + {12'h000, b[3:0]} - DELTA_BIAS;
                            prev_tile = sum ^ {4'h0, b[5:4], 10'h000};
                            remember_tile(prev_tile);
                            void'(push_tile(prev_tile));
                        end
                        CLS_STEP:
                        begin
                            cnt = int'(b[4:0]) + 1;
                            while (cnt > 0 && tiles_left != 23'd0)
                            begin
                                prev_tile = b[5] ? prev_tile - 16'd1 : prev_tile + 16'd1;
                                void'(push_tile(prev_tile));
                                remember_tile(prev_tile);
                                cnt--;
                            end
                        end
                        default:
                        begin
                            cnt = int'(b[5:0]) + 1;
                            while (cnt > 0 && push_tile(prev_tile))
                                cnt--;
                        end
                    endcase
                end
                if (tiles_left == 23'd0)
                    dec_phase = WAIT_H0;
                if (new_tiles.size() > 0)
                    new_tiles[new_tiles.size() - 1].run_end = 1'b1;
            end
            default:
                dec_phase = WAIT_H1;
        endcase
    endfunction

    // offer one byte in the current burst and wait until it is taken
    task automatic send_byte(input logic [7:0] b, input bit known = 1'b0,
                             input tile_t typed = '0);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 10);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 30);
        end
        burst_left--;
        decode_byte(b);
        if (known)
            pending_tiles.push_back(typed);
        else
            foreach (new_tiles[i])
                pending_tiles.push_back(new_tiles[i]);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_count++;
    endtask

    // stop offering until every predicted tile has come out
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_tiles.size() != 0)
            @(posedge clk);
    endtask

    // one opcode, mostly well formed, some noise bytes
    task automatic send_opcode();
        int pick;
        logic [5:0] cnt;
        pick = $urandom_range(0, 99);
        cnt  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 3));
        if (pick < 14)
        begin
            send_byte(OP_LITERAL);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 32)
            send_byte({CLS_FETCH, 6'($urandom_range(0, 63))});
        else if (pick < 57)
            send_byte({CLS_DELTA, 6'($urandom_range(0, 63))});
        else if (pick < 75)
            send_byte({CLS_STEP, 1'($urandom_range(0, 1)), cnt[4:0]});
        else if (pick < 90)
            send_byte({CLS_REPEAT, (cnt == 6'h3F) ? 6'h3E : cnt});
        else
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // header with a random length, then opcodes until the stream closes
    task automatic run_stream();
        int pick;
        int entries;
        logic [23:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            entries = 0;
        else if (pick < 78)
            entries = $urandom_range(1, 24);
        else if (pick < 95)
            entries = $urandom_range(25, 80);
        else
            entries = $urandom_range(100, 300);
        len = 24'(entries * 2 + $urandom_range(0, 1));
        send_byte(8'($urandom_range(0, 255)));
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        send_byte(len[23:16]);
        while (dec_phase != WAIT_H0)
            send_opcode();
    endtask

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: tile %0d %s got %h want %h", $time, tile_count, field, got, want);
        err_count++;
    endtask

    // check each output item against the oldest prediction
    always @(posedge clk)
    begin : check_tiles
        tile_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_tiles.size() == 0)
                report_mismatch("unexpected item, entry", m_tdata, 16'h0000);
            else
            begin
                want = pending_tiles.pop_front();
                if (m_tdata !== want.entry)
                    report_mismatch("tile_entry", m_tdata, want.entry);
                if (m_tlast !== want.run_end)
                    report_mismatch("run_end", 16'(m_tlast), 16'(want.run_end));
                if (m_tuser !== want.stream_end)
                    report_mismatch("stream_end", 16'(m_tuser), 16'(want.stream_end));
            end
            tile_count++;
        end
    end

    // receiver stall pattern, with one long hold-off
    initial
    begin : sink
        int mode;
        int span;
        bit held;
        logic [3:0] tick;
        m_tready = 1'b0;
        held     = 1'b0;
        tick     = 4'd0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 150);
            repeat (span)
            begin
                @(posedge clk);
                if (!held && sent_count >= HOLD_AFTER)
                begin
                    held = 1'b1;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                tick = tick + 4'd1;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 4) == 0);
                    default: m_tready <= tick[1];
                endcase
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("tilemap_stream_decoder_unit_test: errors");
        $finish;
    end

    // reset, directed table, random streams, final long stream
    initial
    begin
        int streams;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        rst_n      = 1'b0;
        err_count  = 0;
        sent_count = 0;
        tile_count = 0;
        burst_left = 0;
        foreach (hist_copy[i])
            hist_copy[i] = 16'h0000;
        prev_tile  = 16'h0000;
        tiles_left = 23'd0;
        dec_phase  = WAIT_H0;
        lit_byte   = 8'h00;
        len_word   = 16'h0000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
            send_byte(dir_rows[i].data, dir_rows[i].known, dir_rows[i].tile);

        streams = 0;
        while (sent_count < N_DIR + RANDOM_ITEMS)
        begin
            run_stream();
            streams++;
            if (streams == 3 || $urandom_range(0, 7) == 0)
                wait_for_drain();
        end

        // largest declared length, left open
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFE);
        send_byte(8'h7A);
        send_byte(8'h9C);
        send_byte(8'h3F);
        send_byte(8'hC5);

        s_tvalid <= 1'b0;
        while (pending_tiles.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_tiles.size() == 0)
            $display("tilemap_stream_decoder_unit_test: clean");
        else
            $display("tilemap_stream_decoder_unit_test: errors");
        $finish;
    end

endmodule
